@@ hw/rtl/ffpa_pkg.sv @@
// Shared types and constants for the first-fit partition allocator.
`timescale 1ns / 1ps

package ffpa_pkg;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_SIZE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_REMAINDER = 2'd1;

  // Register reset values
  localparam logic [15:0] DEFAULT_TOTAL  = 16'd1024;
  localparam logic [15:0] DEFAULT_MINREM = 16'd16;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_MEM    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Shared arithmetic unit operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

@@ hw/rtl/ffpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ffpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/ffpa_alu.sv @@
// Shared add/subtract unit with carry-based compare and equality check.
`timescale 1ns / 1ps

module ffpa_alu import ffpa_pkg::*; #(
  parameter int W = 17
) (
  input  alu_op_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] c,
  output logic [W:0]   res,
  output logic         ge,
  output logic         eq
);

  // a + b, or a - b as a + ~b + 1 with the carry kept
  assign res = (op == ALU_SUB) ? ({1'b0, a} + {1'b0, ~b} + (W+1)'(1))
                               : ({1'b0, a} + {1'b0, b});
  // carry out of a subtract: a >= b
  assign ge  = res[W];
  assign eq  = (res[W-1:0] == c);

endmodule

@@ hw/rtl/first_fit_partition_allocator_unit.sv @@
// Top level: first-fit partition allocator with hole merging and compaction.
//
//   channel | direction | handshake          | beat contents
//   cfg     | in        | cfg_we             | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready  | op, target_id, alloc_size
//   out     | out       | out_valid/out_ready| status, block_id, start_address,
//           |           |                    | granted_size, compacted
//
// One request at a time; in_ready is high only while the sequencer idles.
// Allocate: a scan of the holes plus a shift of the entries behind a dropped
// hole; a compaction adds an insertion sort of the used table by start
// address and a repack of every used entry.
// Free: a search of the used and hole tables and a shift of entries.
// All table traffic goes through one RAM port pair per table, and the size and
// address arithmetic on table entries goes through the one shared arithmetic unit.
// After reset or a nonzero total_size write, the S_INIT state rebuilds the single hole.
// A finished result waits in the output register; a new beat is taken meanwhile.
`timescale 1ns / 1ps

module first_fit_partition_allocator_unit import ffpa_pkg::*; #(
  parameter int FREE_SLOTS = 32,
  parameter int USED_SLOTS = 32,
  parameter int ADDR_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    op,
  input  logic [15:0]             target_id,
  input  logic [15:0]             alloc_size,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              status,
  output logic [15:0]             block_id,
  output logic [15:0]             start_address,
  output logic [15:0]             granted_size,
  output logic                    compacted
);

  localparam int A   = ADDR_BITS;
  localparam int W   = (A > 16 ? A : 16) + 1;
  localparam int FIB = $clog2(FREE_SLOTS);
  localparam int UIB = USED_SLOTS > 1 ? $clog2(USED_SLOTS) : 1;
  localparam int FCB = $clog2(FREE_SLOTS + 1);
  localparam int UCB = $clog2(USED_SLOTS + 1);
  localparam int CW  = (FCB > UCB ? FCB : UCB) + 1;
  localparam int FEW = 2 * A;
  localparam int UEW = 16 + 2 * A;
  localparam logic [W-1:0] AMASK = W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [15:0] RESET_TOTAL =
    (W'(DEFAULT_TOTAL) > AMASK) ? 16'(AMASK) : DEFAULT_TOTAL;

  typedef enum logic [31:0] {
    S_INIT       = 32'h0000_0001,
    S_IDLE       = 32'h0000_0002,
    S_A_START    = 32'h0000_0004,
    S_A_SCAN_RD  = 32'h0000_0008,
    S_A_SCAN_CMP = 32'h0000_0010,
    S_A_SCAN_ADD = 32'h0000_0020,
    S_A_NOFIT    = 32'h0000_0040,
    S_C_SORT_RD  = 32'h0000_0080,
    S_C_KEY      = 32'h0000_0100,
    S_C_INS_RD   = 32'h0000_0200,
    S_C_INS_CMP  = 32'h0000_0400,
    S_C_PACK_RD  = 32'h0000_0800,
    S_C_PACK_WR  = 32'h0000_1000,
    S_A_SPLIT_SUB= 32'h0000_2000,
    S_A_SPLIT_CMP= 32'h0000_4000,
    S_A_SPLIT_WR = 32'h0000_8000,
    S_FDROP_RD   = 32'h0001_0000,
    S_FDROP_WR   = 32'h0002_0000,
    S_A_USED_WR  = 32'h0004_0000,
    S_F_URD      = 32'h0008_0000,
    S_F_UCMP     = 32'h0010_0000,
    S_F_KRD      = 32'h0020_0000,
    S_F_KCMP     = 32'h0040_0000,
    S_F_LEFT     = 32'h0080_0000,
    S_F_RIGHT    = 32'h0100_0000,
    S_F_MERGE    = 32'h0200_0000,
    S_F_BOTH2    = 32'h0400_0000,
    S_F_INS_RD   = 32'h0800_0000,
    S_F_INS_WR   = 32'h1000_0000,
    S_F_UDEL_RD  = 32'h2000_0000,
    S_F_UDEL_WR  = 32'h4000_0000,
    S_DONE       = 32'h8000_0000
  } state_t;

  state_t state;

  // config and counters
  logic [15:0]    total_size, min_rem, next_ident;
  logic [FCB-1:0] fc;
  logic [UCB-1:0] uc;

  // per-request working registers
  logic           op_q, left_q, right_q, pack_flag;
  logic [15:0]    id_q, req_q;
  logic [CW-1:0]  idx, jdx, kpos, upos;
  logic [W-1:0]   sum, base, acc;
  logic [A-1:0]   st, ln, diff, prev_st, prev_ln, nxt_st, nxt_ln;
  logic [UEW-1:0] key;

  // pending result
  status_t        r_status;
  logic [15:0]    r_start, r_size;
  logic           r_packed;

  // output register
  status_t        o_status;
  logic [15:0]    o_id, o_start, o_size;
  logic           o_packed;

  // table RAM ports
  logic           f_we, u_we;
  logic [FIB-1:0] f_waddr, f_raddr;
  logic [UIB-1:0] u_waddr, u_raddr;
  logic [FEW-1:0] f_wdata, f_rdata;
  logic [UEW-1:0] u_wdata, u_rdata;

  // shared arithmetic unit
  alu_op_t        alu_op;
  logic [W-1:0]   alu_a, alu_b, alu_c;
  logic [W:0]     alu_res;
  logic           alu_ge, alu_eq;

  logic [CW-1:0]  idx_p1, idx_m1, jdx_m1;
  logic [A-1:0]   f_rst, f_rln, u_rst, u_rln, key_st;
  logic [15:0]    u_rid;
  logic           greater;
  logic           cfg_reinit, load_out;

  assign idx_p1 = idx + CW'(1);
  assign idx_m1 = idx - CW'(1);
  assign jdx_m1 = jdx - CW'(1);
  assign f_rst  = f_rdata[FEW-1:A];
  assign f_rln  = f_rdata[A-1:0];
  assign u_rid  = u_rdata[UEW-1:FEW];
  assign u_rst  = u_rdata[FEW-1:A];
  assign u_rln  = u_rdata[A-1:0];
  assign key_st = key[FEW-1:A];
  assign greater = alu_ge && !alu_eq;

  // a nonzero total_size write rebuilds the tables
  assign cfg_reinit = cfg_we && (cfg_index == REG_TOTAL_SIZE) && (cfg_data != '0);
  // finished result moves into the output register
  assign load_out   = (state == S_DONE) && (!out_valid || out_ready) && !cfg_reinit;

  ffpa_ram #(.WIDTH(FEW), .DEPTH(FREE_SLOTS)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  ffpa_ram #(.WIDTH(UEW), .DEPTH(USED_SLOTS)) u_used_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  ffpa_alu #(.W(W)) u_alu (
    .op(alu_op), .a(alu_a), .b(alu_b), .c(alu_c),
    .res(alu_res), .ge(alu_ge), .eq(alu_eq)
  );

  // RAM and arithmetic unit steering
  always_comb begin
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
    u_we = 1'b0; u_waddr = '0; u_wdata = '0; u_raddr = '0;
    alu_op = ALU_ADD; alu_a = '0; alu_b = '0; alu_c = '0;
    unique case (state)
      S_INIT: begin
        f_we = 1'b1;
        f_wdata = {A'(0), A'(total_size)};
      end
      S_A_SCAN_RD: f_raddr = idx[FIB-1:0];
      S_A_SCAN_CMP: begin
        alu_op = ALU_SUB; alu_a = W'(f_rln); alu_b = W'(req_q);
      end
      S_A_SCAN_ADD: begin
        alu_a = sum; alu_b = W'(ln);
      end
      S_A_NOFIT: begin
        alu_op = ALU_SUB; alu_a = sum; alu_b = W'(req_q);
      end
      S_C_SORT_RD: u_raddr = idx[UIB-1:0];
      S_C_INS_RD: begin
        if (jdx == '0) begin
          u_we = 1'b1; u_waddr = '0; u_wdata = key;
        end else begin
          u_raddr = jdx_m1[UIB-1:0];
        end
      end
      S_C_INS_CMP: begin
        alu_op = ALU_SUB; alu_a = W'(u_rst); alu_b = W'(key_st);
        u_we = 1'b1; u_waddr = jdx[UIB-1:0];
        u_wdata = greater ? u_rdata : key;
      end
      S_C_PACK_RD: begin
        if (idx == CW'(uc)) begin
          f_we = 1'b1; f_wdata = {A'(0), A'(sum)};
        end else begin
          u_raddr = idx[UIB-1:0];
        end
      end
      S_C_PACK_WR: begin
        alu_a = base; alu_b = W'(u_rln);
        u_we = 1'b1; u_waddr = idx[UIB-1:0];
        u_wdata = {u_rid, A'(base), u_rln};
      end
      S_A_SPLIT_SUB: begin
        alu_op = ALU_SUB; alu_a = W'(ln); alu_b = W'(req_q);
      end
      S_A_SPLIT_CMP: begin
        alu_op = ALU_SUB; alu_a = W'(min_rem); alu_b = W'(diff);
      end
      S_A_SPLIT_WR: begin
        alu_a = W'(st); alu_b = W'(req_q);
        f_we = 1'b1; f_waddr = kpos[FIB-1:0];
        f_wdata = {A'(alu_res), diff};
      end
      S_FDROP_RD: f_raddr = idx_p1[FIB-1:0];
      S_FDROP_WR: begin
        f_we = 1'b1; f_waddr = idx[FIB-1:0]; f_wdata = f_rdata;
      end
      S_A_USED_WR: begin
        u_we = 1'b1; u_waddr = uc[UIB-1:0]; u_wdata = {id_q, st, ln};
      end
      S_F_URD: u_raddr = idx[UIB-1:0];
      S_F_UCMP: begin
        alu_a = W'(u_rid); alu_c = W'(id_q);
      end
      S_F_KRD: f_raddr = idx[FIB-1:0];
      S_F_KCMP: begin
        alu_op = ALU_SUB; alu_a = W'(f_rst); alu_b = W'(st);
      end
      S_F_LEFT: begin
        alu_a = W'(prev_st); alu_b = W'(prev_ln); alu_c = W'(st);
      end
      S_F_RIGHT: begin
        alu_a = W'(st); alu_b = W'(ln); alu_c = W'(nxt_st);
      end
      S_F_MERGE: begin
        if (left_q) begin
          alu_a = W'(prev_ln); alu_b = W'(ln);
          if (!right_q) begin
            f_we = 1'b1; f_waddr = idx_m1[FIB-1:0];
            f_wdata = {prev_st, A'(alu_res)};
          end
        end else if (right_q) begin
          alu_a = W'(nxt_ln); alu_b = W'(ln);
          f_we = 1'b1; f_waddr = idx[FIB-1:0];
          f_wdata = {st, A'(alu_res)};
        end
      end
      S_F_BOTH2: begin
        alu_a = acc; alu_b = W'(nxt_ln);
        f_we = 1'b1; f_waddr = idx_m1[FIB-1:0];
        f_wdata = {prev_st, A'(alu_res)};
      end
      S_F_INS_RD: begin
        if (idx == kpos) begin
          f_we = 1'b1; f_waddr = kpos[FIB-1:0]; f_wdata = {st, ln};
        end else begin
          f_raddr = idx_m1[FIB-1:0];
        end
      end
      S_F_INS_WR: begin
        f_we = 1'b1; f_waddr = idx[FIB-1:0]; f_wdata = f_rdata;
      end
      S_F_UDEL_RD: u_raddr = idx_p1[UIB-1:0];
      S_F_UDEL_WR: begin
        u_we = 1'b1; u_waddr = idx[UIB-1:0]; u_wdata = u_rdata;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      total_size <= RESET_TOTAL;
      min_rem    <= DEFAULT_MINREM;
      next_ident <= '0;
      fc         <= '0;
      uc         <= '0;
      out_valid  <= 1'b0;
    end else begin
      // output beat handshake
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TOTAL_SIZE: begin
            if (cfg_data != '0) begin
              total_size <= (W'(cfg_data) > AMASK) ? 16'(AMASK) : cfg_data;
            end
          end
          REG_MIN_REMAINDER: min_rem <= cfg_data;
          default: ;
        endcase
      end

      if (cfg_reinit) begin
        state <= S_INIT;
      end else begin
        unique case (state)
          S_INIT: begin
            fc    <= FCB'(1);
            uc    <= '0;
            state <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              op_q  <= op;
              req_q <= alloc_size;
              idx   <= '0;
              if (op == OP_ALLOC) begin
                next_ident <= next_ident + 16'd1;
                id_q       <= next_ident + 16'd1;
                state      <= S_A_START;
              end else begin
                id_q  <= target_id;
                state <= S_F_URD;
              end
            end
          end
          S_A_START: begin
            pack_flag <= 1'b0;
            sum       <= '0;
            r_start <= '0; r_size <= '0; r_packed <= 1'b0;
            if (req_q == '0) begin
              r_status <= ST_BAD_SIZE; state <= S_DONE;
            end else if (CW'(uc) == CW'(USED_SLOTS)) begin
              r_status <= ST_FULL; state <= S_DONE;
            end else begin
              state <= S_A_SCAN_RD;
            end
          end
          S_A_SCAN_RD: begin
            state <= (idx == CW'(fc)) ? S_A_NOFIT : S_A_SCAN_CMP;
          end
          S_A_SCAN_CMP: begin
            st <= f_rst;
            ln <= f_rln;
            if (alu_ge) begin
              kpos  <= idx;
              state <= S_A_SPLIT_SUB;
            end else begin
              state <= S_A_SCAN_ADD;
            end
          end
          S_A_SCAN_ADD: begin
            sum   <= W'(alu_res);
            idx   <= idx_p1;
            state <= S_A_SCAN_RD;
          end
          S_A_NOFIT: begin
            if (!alu_ge) begin
              r_status <= ST_NO_MEM; state <= S_DONE;
            end else begin
              pack_flag <= 1'b1;
              idx       <= CW'(1);
              state     <= S_C_SORT_RD;
            end
          end
          // insertion sort of the used table by start address
          S_C_SORT_RD: begin
            if (idx >= CW'(uc)) begin
              base  <= sum;
              idx   <= '0;
              state <= S_C_PACK_RD;
            end else begin
              state <= S_C_KEY;
            end
          end
          S_C_KEY: begin
            key   <= u_rdata;
            jdx   <= idx;
            state <= S_C_INS_RD;
          end
          S_C_INS_RD: begin
            if (jdx == '0) begin
              idx   <= idx_p1;
              state <= S_C_SORT_RD;
            end else begin
              state <= S_C_INS_CMP;
            end
          end
          S_C_INS_CMP: begin
            if (greater) begin
              jdx   <= jdx_m1;
              state <= S_C_INS_RD;
            end else begin
              idx   <= idx_p1;
              state <= S_C_SORT_RD;
            end
          end
          // repack used blocks above the merged hole
          S_C_PACK_RD: begin
            if (idx == CW'(uc)) begin
              fc    <= FCB'(1);
              kpos  <= '0;
              st    <= '0;
              ln    <= A'(sum);
              state <= S_A_SPLIT_SUB;
            end else begin
              state <= S_C_PACK_WR;
            end
          end
          S_C_PACK_WR: begin
            base  <= W'(alu_res);
            idx   <= idx_p1;
            state <= S_C_PACK_RD;
          end
          S_A_SPLIT_SUB: begin
            diff  <= A'(alu_res);
            state <= S_A_SPLIT_CMP;
          end
          S_A_SPLIT_CMP: begin
            if (alu_ge) begin
              idx   <= kpos;
              state <= S_FDROP_RD;
            end else begin
              state <= S_A_SPLIT_WR;
            end
          end
          S_A_SPLIT_WR: begin
            ln    <= A'(req_q);
            state <= S_A_USED_WR;
          end
          // close the gap left by a removed hole
          S_FDROP_RD: begin
            if (idx_p1 >= CW'(fc)) begin
              fc <= fc - FCB'(1);
              if (op_q == OP_ALLOC) begin
                state <= S_A_USED_WR;
              end else begin
                idx   <= upos;
                state <= S_F_UDEL_RD;
              end
            end else begin
              state <= S_FDROP_WR;
            end
          end
          S_FDROP_WR: begin
            idx   <= idx_p1;
            state <= S_FDROP_RD;
          end
          S_A_USED_WR: begin
            uc       <= uc + UCB'(1);
            r_status <= ST_OK;
            r_start  <= 16'(st);
            r_size   <= 16'(ln);
            r_packed <= pack_flag;
            state    <= S_DONE;
          end
          // free: look up the ident
          S_F_URD: begin
            r_start <= '0; r_size <= '0; r_packed <= 1'b0;
            if (idx == CW'(uc)) begin
              r_status <= ST_NOT_FOUND; state <= S_DONE;
            end else begin
              state <= S_F_UCMP;
            end
          end
          S_F_UCMP: begin
            if (alu_eq) begin
              st    <= u_rst;
              ln    <= u_rln;
              upos  <= idx;
              idx   <= '0;
              state <= S_F_KRD;
            end else begin
              idx   <= idx_p1;
              state <= S_F_URD;
            end
          end
          // find the first hole at or above the block
          S_F_KRD: begin
            state <= (idx == CW'(fc)) ? S_F_LEFT : S_F_KCMP;
          end
          S_F_KCMP: begin
            if (alu_ge) begin
              nxt_st <= f_rst;
              nxt_ln <= f_rln;
              state  <= S_F_LEFT;
            end else begin
              prev_st <= f_rst;
              prev_ln <= f_rln;
              idx     <= idx_p1;
              state   <= S_F_KRD;
            end
          end
          S_F_LEFT: begin
            left_q <= (idx != '0) && alu_eq;
            state  <= S_F_RIGHT;
          end
          S_F_RIGHT: begin
            right_q <= (idx < CW'(fc)) && alu_eq;
            state   <= S_F_MERGE;
          end
          S_F_MERGE: begin
            if (!left_q && !right_q && CW'(fc) == CW'(FREE_SLOTS)) begin
              r_status <= ST_FULL; state <= S_DONE;
            end else if (left_q && right_q) begin
              acc   <= W'(alu_res);
              state <= S_F_BOTH2;
            end else if (left_q || right_q) begin
              idx   <= upos;
              state <= S_F_UDEL_RD;
            end else begin
              kpos  <= idx;
              idx   <= CW'(fc);
              state <= S_F_INS_RD;
            end
          end
          S_F_BOTH2: begin
            state <= S_FDROP_RD;
          end
          // open a slot for a new hole
          S_F_INS_RD: begin
            if (idx == kpos) begin
              fc    <= fc + FCB'(1);
              idx   <= upos;
              state <= S_F_UDEL_RD;
            end else begin
              state <= S_F_INS_WR;
            end
          end
          S_F_INS_WR: begin
            idx   <= idx_m1;
            state <= S_F_INS_RD;
          end
          // remove the freed entry from the used table
          S_F_UDEL_RD: begin
            if (idx_p1 >= CW'(uc)) begin
              uc       <= uc - UCB'(1);
              r_status <= ST_OK;
              r_start  <= 16'(st);
              r_size   <= 16'(ln);
              r_packed <= 1'b0;
              state    <= S_DONE;
            end else begin
              state <= S_F_UDEL_WR;
            end
          end
          S_F_UDEL_WR: begin
            idx   <= idx_p1;
            state <= S_F_UDEL_RD;
          end
          S_DONE: begin
            if (load_out) begin
              o_status <= r_status;
              o_id     <= id_q;
              o_start  <= r_start;
              o_size   <= r_size;
              o_packed <= r_packed;
              state    <= S_IDLE;
            end
          end
          default: state <= S_INIT;
        endcase
      end
    end
  end

  assign in_ready      = (state == S_IDLE) && !cfg_reinit;
  assign status        = o_status;
  assign block_id      = o_id;
  assign start_address = o_start;
  assign granted_size  = o_size;
  assign compacted     = o_packed;

  // table counts stay within capacity
  a_free_cap: assert property (@(posedge clk) disable iff (rst)
    CW'(fc) <= CW'(FREE_SLOTS))
    else $error("free count over capacity");

  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    CW'(uc) <= CW'(USED_SLOTS))
    else $error("used count over capacity");

  // an accepted request makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready after accept");

  // each allocate request advances the ident counter by one
  a_ident: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == OP_ALLOC) |=>
      next_ident == 16'($past(next_ident) + 16'd1))
    else $error("ident counter did not advance");

endmodule

@@ tb/tb_first_fit_partition_allocator_unit.sv @@
// Testbench for the first-fit partition allocator: directed and random requests checked beat by beat.
`timescale 1ns / 1ps

module tb_first_fit_partition_allocator_unit;
  import ffpa_pkg::*;

  localparam int NFREE = 32;
  localparam int NUSED = 32;
  localparam int WATCHDOG_LIMIT = 50000;

  typedef struct packed {
    logic        op;
    logic [15:0] tid;
    logic [15:0] rsz;
  } req_t;

  typedef struct packed {
    status_t     st;
    logic [15:0] id;
    logic [15:0] addr;
    logic [15:0] len;
    logic        packed_f;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = OP_ALLOC;
  logic [15:0] target_id = '0;
  logic [15:0] alloc_size = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [15:0] block_id, start_address, granted_size;
  logic compacted;

  first_fit_partition_allocator_unit dut (.*);

  always #5 clk = ~clk;

  // Shadow allocator state
  int unsigned hole_at[NFREE], hole_len[NFREE], hole_cnt;
  int unsigned blk_id[NUSED], blk_at[NUSED], blk_len[NUSED], blk_cnt;
  int unsigned ident_ctr, mem_total, keep_whole;

  req_t   pending_reqs[$];
  grant_t expected_grants[$];
  int     idle_pct, stall_pct, hold_left, errors, beats_out, packs_seen, ok_seen;
  bit     hold_req;

  // Generation-side view: ids handed out by queued allocates
  int unsigned gen_ident, gen_total;
  int unsigned live_ids[$];

  function automatic void reset_tables();
    hole_at[0] = 0;
    hole_len[0] = mem_total;
    hole_cnt = 1;
    blk_cnt = 0;
  endfunction

  function automatic void drop_hole(int unsigned k);
    for (int unsigned i = k; i + 1 < hole_cnt; i++) begin
      hole_at[i] = hole_at[i+1];
      hole_len[i] = hole_len[i+1];
    end
    hole_cnt--;
  endfunction

  // Sort used blocks by address, repack them above one hole at address 0
  function automatic void pack_memory(int unsigned total_free);
    int unsigned j, id, at, ln, base;
    for (int unsigned i = 1; i < blk_cnt; i++) begin
      id = blk_id[i]; at = blk_at[i]; ln = blk_len[i];
      j = i;
      while (j > 0 && blk_at[j-1] > at) begin
        blk_id[j] = blk_id[j-1]; blk_at[j] = blk_at[j-1]; blk_len[j] = blk_len[j-1];
        j--;
      end
      blk_id[j] = id; blk_at[j] = at; blk_len[j] = ln;
    end
    base = total_free;
    for (int unsigned i = 0; i < blk_cnt; i++) begin
      blk_at[i] = base & 16'hFFFF;
      base += blk_len[i];
    end
    hole_at[0] = 0;
    hole_len[0] = total_free & 16'hFFFF;
    hole_cnt = 1;
  endfunction

  function automatic grant_t predict_grant(req_t r);
    grant_t g;
    int unsigned pick, total_free, at, ln, u, k;
    bit lft, rgt;
    g = '0;
    if (r.op == OP_ALLOC) begin
      ident_ctr = (ident_ctr + 1) & 16'hFFFF;
      g.id = 16'(ident_ctr);
      if (r.rsz == 0) begin
        g.st = ST_BAD_SIZE; return g;
      end
      if (blk_cnt >= NUSED) begin
        g.st = ST_FULL; return g;
      end
      pick = hole_cnt; total_free = 0;
      for (int unsigned i = 0; i < hole_cnt; i++) begin
        if (hole_len[i] >= r.rsz) begin pick = i; break; end
        total_free += hole_len[i];
      end
      if (pick == hole_cnt) begin
        if (total_free < r.rsz) begin
          g.st = ST_NO_MEM; return g;
        end
        pack_memory(total_free);
        g.packed_f = 1'b1;
        pick = 0;
      end
      at = hole_at[pick]; ln = hole_len[pick];
      if (ln - r.rsz <= keep_whole) drop_hole(pick);
      else begin
        hole_at[pick] = (at + r.rsz) & 16'hFFFF;
        hole_len[pick] = ln - r.rsz;
        ln = r.rsz;
      end
      blk_id[blk_cnt] = ident_ctr; blk_at[blk_cnt] = at; blk_len[blk_cnt] = ln;
      blk_cnt++;
      g.st = ST_OK; g.addr = 16'(at); g.len = 16'(ln);
      return g;
    end
    // free: first matching id in table order
    g.id = r.tid;
    for (u = 0; u < blk_cnt; u++) if (blk_id[u] == r.tid) break;
    if (u == blk_cnt) begin
      g.st = ST_NOT_FOUND; return g;
    end
    at = blk_at[u]; ln = blk_len[u];
    for (k = 0; k < hole_cnt && hole_at[k] < at; k++) ;
    lft = k > 0 && hole_at[k-1] + hole_len[k-1] == at;
    rgt = k < hole_cnt && at + ln == hole_at[k];
    if (!lft && !rgt && hole_cnt >= NFREE) begin
      g.st = ST_FULL; return g;
    end
    if (lft && rgt) begin
      hole_len[k-1] = (hole_len[k-1] + ln + hole_len[k]) & 16'hFFFF;
      drop_hole(k);
    end else if (lft) hole_len[k-1] = (hole_len[k-1] + ln) & 16'hFFFF;
    else if (rgt) begin
      hole_at[k] = at;
      hole_len[k] = (hole_len[k] + ln) & 16'hFFFF;
    end else begin
      for (int unsigned i = hole_cnt; i > k; i--) begin
        hole_at[i] = hole_at[i-1]; hole_len[i] = hole_len[i-1];
      end
      hole_at[k] = at; hole_len[k] = ln;
      hole_cnt++;
    end
    for (int unsigned i = u; i + 1 < blk_cnt; i++) begin
      blk_id[i] = blk_id[i+1]; blk_at[i] = blk_at[i+1]; blk_len[i] = blk_len[i+1];
    end
    blk_cnt--;
    g.st = ST_OK; g.addr = 16'(at); g.len = 16'(ln);
    return g;
  endfunction

  // Request driver
  always @(posedge clk) begin
    req_t r;
    if (in_valid && in_ready) expected_grants.push_back(predict_grant({op, target_id, alloc_size}));
    if (rst) in_valid <= 1'b0;
    else if (!in_valid || in_ready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        r = pending_reqs.pop_front();
        op <= r.op; target_id <= r.tid; alloc_size <= r.rsz;
        in_valid <= 1'b1;
      end else in_valid <= 1'b0;
    end
  end

  // Result monitor with random and long stalls
  always @(posedge clk) begin
    grant_t e;
    if (out_valid && out_ready) begin
      beats_out++;
      if (expected_grants.size() == 0) begin
        $error("unexpected result beat, block_id %0d", block_id);
        errors++;
      end else begin
        e = expected_grants.pop_front();
        if (status != e.st) begin
          $error("status: expected %0d, got %0d", e.st, status); errors++;
        end
        if (block_id != e.id) begin
          $error("block_id: expected %0d, got %0d", e.id, block_id); errors++;
        end
        if (start_address != e.addr) begin
          $error("start_address: expected %0d, got %0d", e.addr, start_address); errors++;
        end
        if (granted_size != e.len) begin
          $error("granted_size: expected %0d, got %0d", e.len, granted_size); errors++;
        end
        if (compacted != e.packed_f) begin
          $error("compacted: expected %0d, got %0d", e.packed_f, compacted); errors++;
        end
        if (e.st == ST_OK) ok_seen++;
        packs_seen += e.packed_f;
      end
    end
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else out_ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles without any beat
  int quiet;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    if (idx == REG_TOTAL_SIZE && v != 0) begin
      mem_total = v; gen_total = v;
      reset_tables();
      live_ids.delete();
    end else if (idx == REG_MIN_REMAINDER) keep_whole = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_alloc(input logic [15:0] sz, input logic [15:0] junk = 0);
    gen_ident = (gen_ident + 1) & 16'hFFFF;
    if (sz != 0) live_ids.push_back(gen_ident);
    pending_reqs.push_back({OP_ALLOC, junk, sz});
  endtask

  task automatic push_free(input logic [15:0] id, input logic [15:0] junk = 0);
    foreach (live_ids[i]) if (live_ids[i] == id) begin
      live_ids.delete(i);
      break;
    end
    pending_reqs.push_back({OP_FREE, id, junk});
  endtask

  function automatic int unsigned next_id(int unsigned n);
    return (gen_ident + n) & 16'hFFFF;
  endfunction

  // Mostly frees of live blocks and moderate allocates, plus noise
  task automatic push_random(input int n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 40 && live_ids.size() > 0)
        push_free(16'(live_ids[$urandom_range(live_ids.size() - 1)]), 16'($urandom));
      else if (pick < 46) push_free(16'($urandom), 16'($urandom));
      else if (pick < 50) push_alloc(16'($urandom), 16'($urandom));
      else if (pick < 53) push_alloc(16'd0);
      else push_alloc(16'($urandom_range(1, gen_total / 5 + 1)), 16'($urandom));
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_grants.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int unsigned a;
    mem_total = DEFAULT_TOTAL; keep_whole = DEFAULT_MINREM; ident_ctr = 0;
    gen_total = DEFAULT_TOTAL; gen_ident = 0;
    reset_tables();
    idle_pct = 0; stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: bad size, no memory, split, middle hole, misses, compaction, merges
    push_alloc(16'd0);
    push_alloc(16'hFFFF);
    a = next_id(1);
    push_alloc(16'd100, 16'hFFFF);
    push_alloc(16'd200);
    push_alloc(16'd100);
    push_free(16'(a + 1), 16'hFFFF);
    push_free(16'd999);
    push_free(16'hFFFF);
    push_alloc(16'd700);             // fits only after compaction
    push_free(16'(a));               // merges with the hole on its left
    push_free(16'(a + 2));
    push_free(16'(next_id(0)));      // merges with the hole on its right
    push_alloc(16'd1020);            // leftover small, granted whole
    push_free(16'(next_id(0)));
    push_alloc(16'd1024);
    push_free(16'(next_id(0)));
    push_free(16'(next_id(0)));      // already gone
    drain();
    push_random(200);
    drain();

    // Exact fits, used table overflow, long receiver stall
    write_reg(REG_MIN_REMAINDER, 16'd0);
    write_reg(REG_TOTAL_SIZE, 16'd1024);
    repeat (34) push_alloc(16'd1);
    idle_pct = 59;
    fork
      push_random(220);
      begin
        repeat (50) @(posedge clk);
        hold_req = 1'b1;
      end
    join
    drain();

    // Largest memory, everything granted whole
    write_reg(REG_TOTAL_SIZE, 16'hFFFF);
    write_reg(REG_MIN_REMAINDER, 16'hFFFF);
    idle_pct = 0; stall_pct = 59;
    push_random(160);
    drain();

    // Smallest memory; writes that must be ignored
    write_reg(REG_TOTAL_SIZE, 16'd1);
    write_reg(REG_TOTAL_SIZE, 16'd0);
    write_reg(2'd2, 16'h5555);
    write_reg(2'd3, 16'hAAAA);
    idle_pct = 24; stall_pct = 24;
    push_random(120);
    drain();

    write_reg(REG_TOTAL_SIZE, 16'd300);
    write_reg(REG_MIN_REMAINDER, 16'd8);
    push_random(280);
    drain();

    write_reg(REG_TOTAL_SIZE, 16'hFFFF);
    write_reg(REG_MIN_REMAINDER, 16'd0);
    idle_pct = 0; stall_pct = 0;
    push_random(300);
    drain();

    $display("Run summary: %0d results checked, %0d granted or released, %0d compactions.",
             beats_out, ok_seen, packs_seen);
    $display("Memory sizes from 1 to 65535 words, split thresholds 0 to 65535, stalls on both sides.");
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
